@@ hw/rtl/npcm_pkg.sv @@
// Shared types and constants for the nearest palette colour match unit.
// No dependencies; every other file uses this package.
package npcm_pkg;

  // Palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);

  // Field widths
  localparam int IDX_W   = 8;
  localparam int CHAN_W  = 8;
  localparam int ENTRY_W = 3 * CHAN_W;
  localparam int COUNT_W = 9;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int COST_W  = 23;

  // Luma-style channel weights
  localparam logic [6:0] WEIGHT_RED   = 7'd30;
  localparam logic [6:0] WEIGHT_GREEN = 7'd59;
  localparam logic [6:0] WEIGHT_BLUE  = 7'd11;

  // Start cost: above any reachable score
  localparam logic [COST_W-1:0] COST_START = '1;

  // Register stages from memory read data to the compare
  localparam int PIPE_DEPTH = 3;
  localparam int DRAIN_W    = $clog2(PIPE_DEPTH);

  // Item mode codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Tag that travels with each palette entry through the cost pipeline
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] idx;
  } tag_t;

endpackage

@@ hw/rtl/npcm_if.sv @@
// Handshake channels of the nearest palette colour match unit.
// Depends on npcm_pkg for field widths.

// Input item channel: palette load or colour query
interface npcm_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [npcm_pkg::IDX_W-1:0]   entry_index;
  logic [npcm_pkg::CHAN_W-1:0]  red;
  logic [npcm_pkg::CHAN_W-1:0]  green;
  logic [npcm_pkg::CHAN_W-1:0]  blue;

  modport source (output valid, mode, entry_index, red, green, blue, input ready);
  modport sink   (input valid, mode, entry_index, red, green, blue, output ready);
endinterface

// Result item channel
interface npcm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [npcm_pkg::IDX_W-1:0]   best_index;
  logic [npcm_pkg::COST_W-1:0]  best_cost;

  modport source (output valid, best_index, best_cost, input ready);
  modport sink   (input valid, best_index, best_cost, output ready);
endinterface

// Configuration write channel: colour count register
interface npcm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [npcm_pkg::COUNT_W-1:0] color_count;

  modport source (output valid, color_count, input ready);
  modport sink   (input valid, color_count, output ready);
endinterface

@@ hw/rtl/nearest_palette_color_match_unit.sv @@
// Nearest palette colour match unit: palette memory, scan sequencer, best-entry tracking.
// Loads give no result. A query over N entries (N = colour count, 0 read as 1, capped at
// the depth) is scanned with one memory read per cycle, then passes three pipeline stages
// and one output register. New items are taken only while the sequencer is idle; a
// finished query holds the input off only while an earlier result is not taken.
// Reset is synchronous: count = 1, sequencer idle, no result; palette undefined until loaded.
module nearest_palette_color_match_unit (
  input logic  clk,
  input logic  rst,
  npcm_req_if.sink   request,
  npcm_rsp_if.source response,
  npcm_cfg_if.sink   setup
);
  import npcm_pkg::*;

  // Palette memory
  logic [ENTRY_W-1:0] palette [PALETTE_DEPTH];
  logic [ENTRY_W-1:0] rdata;

  state_t state, state_next;

  logic [COUNT_W-1:0] color_count;
  logic [ADDR_W-1:0]  addr, last_addr, last_next;
  logic [DRAIN_W-1:0] drain_cnt;
  logic [CHAN_W-1:0]  q_red, q_green, q_blue;
  logic [ADDR_W-1:0]  best_idx;
  logic [COST_W-1:0]  best_cost;
  logic               rsp_valid;
  logic [IDX_W-1:0]   rsp_index;
  logic [COST_W-1:0]  rsp_cost;

  logic  req_acc, load_acc, query_acc, issue, finish, load_in_range;
  tag_t  tag_rd, tag_cost;
  logic [COST_W-1:0] cost;

  assign request.ready = (state == ST_IDLE);
  assign setup.ready   = 1'b1;
  assign req_acc       = request.valid && request.ready;
  assign load_acc      = req_acc && (request.mode == MODE_LOAD);
  assign query_acc     = req_acc && (request.mode == MODE_QUERY);
  assign issue         = (state == ST_SCAN);
  assign finish        = (state == ST_DONE) && (!rsp_valid || response.ready);
  assign load_in_range = ({1'b0, request.entry_index} < (IDX_W+1)'(PALETTE_DEPTH));

  // Last entry to scan: zero count reads as one, large counts saturate
  always_comb begin
    if (color_count == '0) begin
      last_next = '0;
    end else if (color_count >= COUNT_W'(PALETTE_DEPTH)) begin
      last_next = ADDR_W'(PALETTE_DEPTH - 1);
    end else begin
      last_next = ADDR_W'(color_count - COUNT_W'(1));
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      color_count <= COUNT_W'(1);
    end else if (setup.valid && setup.ready) begin
      color_count <= setup.color_count;
    end
  end

  // Memory write port (loads) and registered read port (scan)
  always_ff @(posedge clk) begin
    if (load_acc && load_in_range) begin
      palette[request.entry_index[ADDR_W-1:0]] <=
        {request.red, request.green, request.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= palette[addr];
    end
  end

  // Query colour and scan bounds
  always_ff @(posedge clk) begin
    if (query_acc) begin
      q_red     <= request.red;
      q_green   <= request.green;
      q_blue    <= request.blue;
      last_addr <= last_next;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (query_acc) state_next = ST_SCAN;
      ST_SCAN:  if (addr == last_addr) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_cnt == DRAIN_W'(PIPE_DEPTH - 1)) state_next = ST_DONE;
      ST_DONE:  if (finish) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Read address, read tag and drain counter
  always_ff @(posedge clk) begin
    tag_rd.idx <= addr;
    if (rst) begin
      addr      <= '0;
      drain_cnt <= '0;
      tag_rd.valid <= 1'b0;
    end else begin
      tag_rd.valid <= issue;
      if (query_acc) begin
        addr      <= '0;
        drain_cnt <= '0;
      end else begin
        if (issue) addr <= addr + ADDR_W'(1);
        if (state == ST_DRAIN) drain_cnt <= drain_cnt + DRAIN_W'(1);
      end
    end
  end

  // Cost pipeline
  npcm_cost u_cost (
    .clk     (clk),
    .rst     (rst),
    .entry   (rdata),
    .q_red   (q_red),
    .q_green (q_green),
    .q_blue  (q_blue),
    .tag_in  (tag_rd),
    .tag_out (tag_cost),
    .cost    (cost)
  );

  // Best entry so far; strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (query_acc) begin
      best_idx  <= '0;
      best_cost <= COST_START;
    end else if (tag_cost.valid && (cost < best_cost)) begin
      best_idx  <= tag_cost.idx;
      best_cost <= cost;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (response.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_index <= IDX_W'(best_idx);
      rsp_cost  <= best_cost;
    end
  end

  assign response.valid      = rsp_valid;
  assign response.best_index = rsp_index;
  assign response.best_cost  = rsp_cost;

endmodule

@@ hw/rtl/npcm_cost.sv @@
// Two-stage weighted squared distance pipeline for one palette entry.
// Depends on npcm_pkg for widths, weights and the tag type.
module npcm_cost (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [npcm_pkg::ENTRY_W-1:0] entry,
  input  logic [npcm_pkg::CHAN_W-1:0]  q_red,
  input  logic [npcm_pkg::CHAN_W-1:0]  q_green,
  input  logic [npcm_pkg::CHAN_W-1:0]  q_blue,
  input  npcm_pkg::tag_t               tag_in,
  output npcm_pkg::tag_t               tag_out,
  output logic [npcm_pkg::COST_W-1:0]  cost
);
  import npcm_pkg::*;

  logic [CHAN_W-1:0] e_red, e_green, e_blue;
  logic [CHAN_W-1:0] d_red, d_green, d_blue;
  logic [SQ_W-1:0]   sq_red, sq_green, sq_blue;
  tag_t              tag_sq;

  assign e_red   = entry[3*CHAN_W-1:2*CHAN_W];
  assign e_green = entry[2*CHAN_W-1:CHAN_W];
  assign e_blue  = entry[CHAN_W-1:0];

  // Absolute channel differences
  assign d_red   = (q_red   >= e_red)   ? q_red   - e_red   : e_red   - q_red;
  assign d_green = (q_green >= e_green) ? q_green - e_green : e_green - q_green;
  assign d_blue  = (q_blue  >= e_blue)  ? q_blue  - e_blue  : e_blue  - q_blue;

  // Stage 1: squares
  always_ff @(posedge clk) begin
    sq_red   <= SQ_W'(d_red)   * SQ_W'(d_red);
    sq_green <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_blue  <= SQ_W'(d_blue)  * SQ_W'(d_blue);
  end

  // Stage 2: weighted sum (constant multiplies)
  always_ff @(posedge clk) begin
    cost <= COST_W'(WEIGHT_RED)   * COST_W'(sq_red)
          + COST_W'(WEIGHT_GREEN) * COST_W'(sq_green)
          + COST_W'(WEIGHT_BLUE)  * COST_W'(sq_blue);
  end

  // Tags follow the two stages; valid bits cleared on reset
  always_ff @(posedge clk) begin
    tag_sq.idx  <= tag_in.idx;
    tag_out.idx <= tag_sq.idx;
    if (rst) begin
      tag_sq.valid  <= 1'b0;
      tag_out.valid <= 1'b0;
    end else begin
      tag_sq.valid  <= tag_in.valid;
      tag_out.valid <= tag_sq.valid;
    end
  end

endmodule

@@ tb/nearest_palette_color_match_unit_tb.sv @@
// Self-checking testbench for the nearest palette colour match unit.
// Runs a directed table and then random loads, queries and colour count changes, checking each result
// against a typed answer or a local predictor. Needs npcm_pkg, the npcm_*_if interfaces and the RTL.
module nearest_palette_color_match_unit_tb;
  import npcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 90;
  localparam int NUM_PHASES     = 12;
  localparam int NUM_ROWS       = 21;
  localparam int END_SETTLE     = 300;
  localparam logic [COST_W-1:0] MAX_COST = 23'd6502500;

  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_COUNT} row_kind_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [COST_W-1:0] cost;
  } match_t;

  // One directed step: a load, a query (optionally with a typed answer) or a count write
  typedef struct packed {
    row_kind_t          kind;
    logic [IDX_W-1:0]   index;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [COUNT_W-1:0] count;
    logic               typed;
    match_t             result;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // black entry, exact hit and the far corner
    '{ROW_LOAD,  8'd0,   8'd0,   8'd0,   8'd0,   9'd0, 1'b0, '{8'd0, 23'd0}},
    '{ROW_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   9'd0, 1'b1, '{8'd0, 23'd0}},
    '{ROW_QUERY, 8'd255, 8'd255, 8'd255, 8'd255, 9'd0, 1'b1, '{8'd0, MAX_COST}},
    // white entry sits outside a count of one
    '{ROW_LOAD,  8'd1,   8'd255, 8'd255, 8'd255, 9'd0, 1'b0, '{8'd0, 23'd0}},
    '{ROW_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 9'd0, 1'b1, '{8'd0, MAX_COST}},
    // a count of zero still scans entry 0
    '{ROW_COUNT, 8'd0,   8'd0,   8'd0,   8'd0,   9'd0, 1'b0, '{8'd0, 23'd0}},
    '{ROW_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 9'd0, 1'b1, '{8'd0, MAX_COST}},
    '{ROW_COUNT, 8'd0,   8'd0,   8'd0,   8'd0,   9'd2, 1'b0, '{8'd0, 23'd0}},
    '{ROW_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, 9'd0, 1'b1, '{8'd1, 23'd0}},
    // duplicate white: the lower index must win the tie
    '{ROW_LOAD,  8'd2,   8'd255, 8'd255, 8'd255, 9'd0, 1'b0, '{8'd0, 23'd0}},
    '{ROW_COUNT, 8'd0,   8'd0,   8'd0,   8'd0,   9'd3, 1'b0, '{8'd0, 23'd0}},
    '{ROW_QUERY, 8'd0,   8'd200, 8'd200, 8'd200, 9'd0, 1'b0, '{8'd0, 23'd0}},
    // top entry and pure primaries
    '{ROW_LOAD,  8'd255, 8'h12,  8'h34,  8'h56,  9'd0, 1'b0, '{8'd0, 23'd0}},
    '{ROW_LOAD,  8'd3,   8'd255, 8'd0,   8'd0,   9'd0, 1'b0, '{8'd0, 23'd0}},
    '{ROW_LOAD,  8'd4,   8'd0,   8'd255, 8'd0,   9'd0, 1'b0, '{8'd0, 23'd0}},
    '{ROW_LOAD,  8'd5,   8'd0,   8'd0,   8'd255, 9'd0, 1'b0, '{8'd0, 23'd0}},
    '{ROW_COUNT, 8'd0,   8'd0,   8'd0,   8'd0,   9'd6, 1'b0, '{8'd0, 23'd0}},
    '{ROW_QUERY, 8'd0,   8'd255, 8'd0,   8'd0,   9'd0, 1'b1, '{8'd3, 23'd0}},
    '{ROW_QUERY, 8'd0,   8'd0,   8'd255, 8'd0,   9'd0, 1'b1, '{8'd4, 23'd0}},
    '{ROW_QUERY, 8'd0,   8'd0,   8'd0,   8'd255, 9'd0, 1'b1, '{8'd5, 23'd0}},
    '{ROW_QUERY, 8'd0,   8'd128, 8'd0,   8'd0,   9'd0, 1'b0, '{8'd0, 23'd0}}
  };

  // Colour counts per random phase, extremes included
  localparam logic [COUNT_W-1:0] PHASE_COUNTS [NUM_PHASES] = '{
    9'd256, 9'd1, 9'd511, 9'd7, 9'd0, 9'd257, 9'd16, 9'd3, 9'd64, 9'd2, 9'd33, 9'd200
  };

  logic clk = 1'b0;
  logic rst;

  npcm_req_if request ();
  npcm_rsp_if response ();
  npcm_cfg_if setup ();

  nearest_palette_color_match_unit uut (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response),
    .setup    (setup)
  );

  // Shadow of the block's state
  logic [ENTRY_W-1:0] palette [PALETTE_DEPTH];
  logic [COUNT_W-1:0] color_count_shadow;
  match_t             pending_matches [$];

  int errors = 0;
  int loads_sent;
  int queries_sent;
  int results_checked = 0;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  always #5 clk = ~clk;

  // Entries actually scanned for a given count
  function automatic int unsigned scan_span(logic [COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > PALETTE_DEPTH) return PALETTE_DEPTH;
    return 32'(count);
  endfunction

  // Weighted nearest entry over the entries in use, lowest index on ties
  function automatic match_t nearest_entry(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                           logic [CHAN_W-1:0] b);
    match_t            m;
    int unsigned       best_cost;
    int unsigned       cost;
    int unsigned       dr;
    int unsigned       dg;
    int unsigned       db;
    logic [CHAN_W-1:0] er;
    logic [CHAN_W-1:0] eg;
    logic [CHAN_W-1:0] eb;
    m = '0;
    best_cost = 32'h7fffffff;
    for (int i = 0; i < scan_span(color_count_shadow); i++) begin
      {er, eg, eb} = palette[i];
      dr = 32'((r >= er) ? r - er : er - r);
      dg = 32'((g >= eg) ? g - eg : eg - g);
      db = 32'((b >= eb) ? b - eb : eb - b);
      cost = 30 * dr * dr + 59 * dg * dg + 11 * db * db;
      if (cost < best_cost) begin
        best_cost = cost;
        m.index = i[IDX_W-1:0];
      end
    end
    m.cost = best_cost[COST_W-1:0];
    return m;
  endfunction

  // Channel value biased towards the ends of the range
  function automatic logic [CHAN_W-1:0] pick_channel();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  // sender idle / receiver stall mixes
  function automatic void set_idling(int mix);
    case (mix)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 60; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 60; end
      default: begin idle_pct = 7; stall_pct = 7; end
    endcase
  endfunction

  // Offer one item, wait for it to be taken, then update the shadow state
  task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
                           input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                           input logic [CHAN_W-1:0] b, input logic typed,
                           input match_t typed_result);
    while ($urandom_range(99) < idle_pct) begin
      request.valid <= 1'b0;
      @(posedge clk);
    end
    request.valid       <= 1'b1;
    request.mode        <= mode;
    request.entry_index <= idx;
    request.red         <= r;
    request.green       <= g;
    request.blue        <= b;
    do @(posedge clk); while (!request.ready);
    if (mode == MODE_LOAD) begin
      palette[idx] = {r, g, b};
      loads_sent++;
    end else begin
      pending_matches.push_back(typed ? typed_result : nearest_entry(r, g, b));
      queries_sent++;
    end
  endtask

  // Hold off the sender until every query has been answered
  task automatic settle();
    request.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  // Count write, only once the block has gone quiet
  task automatic write_count(input logic [COUNT_W-1:0] value);
    settle();
    repeat (scan_span(color_count_shadow) + 8) @(posedge clk);
    setup.valid       <= 1'b1;
    setup.color_count <= value;
    do @(posedge clk); while (!setup.ready);
    setup.valid <= 1'b0;
    color_count_shadow = value;
  endtask

  // Random load or query; queries lean on exact hits and near misses
  task automatic random_item();
    int unsigned        roll;
    logic [ENTRY_W-1:0] colour;
    roll = $urandom_range(99);
    if (roll < 40) begin
      if (roll < 8) colour = palette[$urandom_range(PALETTE_DEPTH - 1)];
      else colour = {pick_channel(), pick_channel(), pick_channel()};
      send_item(MODE_LOAD, IDX_W'($urandom_range(255)), colour[23:16], colour[15:8],
                colour[7:0], 1'b0, '0);
    end else begin
      if (roll < 60) colour = palette[$urandom_range(scan_span(color_count_shadow) - 1)];
      else if (roll < 70)
        colour = palette[$urandom_range(scan_span(color_count_shadow) - 1)]
                 ^ ENTRY_W'($urandom & 32'h00070707);
      else colour = {pick_channel(), pick_channel(), pick_channel()};
      send_item(MODE_QUERY, IDX_W'($urandom_range(255)), colour[23:16], colour[15:8],
                colour[7:0], 1'b0, '0);
    end
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) response.ready <= 1'b0;
    else response.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checking against the oldest outstanding query
  always @(posedge clk) begin
    match_t want;
    if (!rst && response.valid && response.ready) begin
      if (pending_matches.size() == 0) begin
        errors++;
        $display("%0t: result with no query outstanding: index %0d cost %0d",
                 $time, response.best_index, response.best_cost);
      end else begin
        want = pending_matches.pop_front();
        results_checked++;
        if (response.best_index !== want.index) begin
          errors++;
          $display("%0t: best_index mismatch: expected %0d, got %0d",
                   $time, want.index, response.best_index);
        end
        if (response.best_cost !== want.cost) begin
          errors++;
          $display("%0t: best_cost mismatch: expected %0d, got %0d",
                   $time, want.cost, response.best_cost);
        end
      end
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (response.valid && response.ready) ||
        (setup.valid && setup.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_matches.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    dir_row_t row;
    rst                 <= 1'b1;
    request.valid       <= 1'b0;
    request.mode        <= MODE_LOAD;
    request.entry_index <= '0;
    request.red         <= '0;
    request.green       <= '0;
    request.blue        <= '0;
    setup.valid         <= 1'b0;
    setup.color_count   <= '0;
    color_count_shadow = 9'd1;
    loads_sent = 0;
    queries_sent = 0;
    set_idling(0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        ROW_COUNT: write_count(row.count);
        ROW_LOAD:  send_item(MODE_LOAD, row.index, row.red, row.green, row.blue, 1'b0, '0);
        default:   send_item(MODE_QUERY, row.index, row.red, row.green, row.blue,
                             row.typed, row.result);
      endcase
    end

    // fill the whole palette so any count is legal from here on
    set_idling(1);
    for (int i = 0; i < PALETTE_DEPTH; i++)
      send_item(MODE_LOAD, i[IDX_W-1:0], pick_channel(), pick_channel(), pick_channel(),
                1'b0, '0);

    // random phases, each with its own count and idling mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_count(PHASE_COUNTS[p]);
      set_idling(p % 4);
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_matches.size() != 0) begin
      $display("%0t: %0d queries never answered", $time, pending_matches.size());
    end

    $display("Run: %0d palette loads, %0d colour queries, %0d results compared.",
             loads_sent, queries_sent, results_checked);
    $display("Colour counts 0 to 511 exercised under four sender/receiver idling mixes.");
    if ((errors == 0) && (pending_matches.size() == 0)) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ nearest_palette_color_match_unit.f @@
hw/rtl/npcm_pkg.sv
hw/rtl/npcm_if.sv
hw/rtl/npcm_cost.sv
hw/rtl/nearest_palette_color_match_unit.sv
tb/nearest_palette_color_match_unit_tb.sv
